### rtl/ptts_pkg.sv
`default_nettype none
package ptts_pkg;
  localparam int MAX_TASKS_DEF = 16;
  localparam int CLOCK_BASE_DEF = 1193182;
  localparam int MAX_FIRES_DEF = 63;
  localparam logic [16:0] RELOAD_MAX = 17'h10000;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_ADD = 3'd1, OP_CHANGE = 3'd2, OP_REMOVE = 3'd3,
    OP_ACTIVATE = 3'd4, OP_CLEAR = 3'd5, OP_SUSPEND = 3'd6, OP_RESUME = 3'd7
  } op_t;

  localparam logic [1:0] KIND_FIRE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_OP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADFREQ = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DECIDE, S_SCAN_RD, S_SCAN, S_INS_RD, S_INS, S_UNL_RD, S_UNL,
    S_MIN_RD, S_MIN, S_TICK_RD, S_TICK, S_FIRE, S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [1:0] status;
    logic [16:0] reload;
    logic [27:0] clock;
    logic chain;
    logic last;
  } result_t;
endpackage
`default_nettype wire

### rtl/periodic_task_tick_scheduler.sv
`default_nettype none
// Add and change requests both hold a divide; any result can be held by output stalls.
// Throughput: one request at a time, taken once the previous last result has left.
// Reset: synchronous rst clears valid/active bits, order length, reload to 65536,
// clocks and suspend; entry and order memories need no clearing.
module periodic_task_tick_scheduler #(
  parameter int CLOCK_BASE = ptts_pkg::CLOCK_BASE_DEF,
  parameter int MAX_FIRES_PER_TICK = ptts_pkg::MAX_FIRES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  // operation[2:0], task_slot[6:3], frequency[27:7], priority_req[35:28], zero fill
  input wire logic [39:0] s_tdata,
  output logic m_tvalid,
  input wire logic m_tready,
  // slot_out[3:0], status[5:4], timer_reload[22:6], clock_value[50:23], chain[51]
  output logic [55:0] m_tdata,
  // kind[1:0]
  output logic [1:0] m_tuser,
  output logic m_tlast
);
  import ptts_pkg::*;

  localparam int MAX_TASKS = MAX_TASKS_DEF;
  localparam int SW = $clog2(MAX_TASKS + 1) > 1 ? $clog2(MAX_TASKS) : 1;
  localparam int LW = $clog2(MAX_TASKS + 1);
  localparam logic [LW-1:0] NT = LW'(MAX_TASKS);

  state_t state, state_next;

  // entry memory: priority, period, accum
  logic [7:0] mem_prio [MAX_TASKS];
  logic [20:0] mem_per [MAX_TASKS];
  logic [31:0] mem_acc [MAX_TASKS];
  logic [SW-1:0] mem_ord [MAX_TASKS];
  logic [SW-1:0] e_addr, o_raddr, o_waddr;
  logic e_we, o_we;
  logic [7:0] e_wprio;
  logic [20:0] e_wper;
  logic [31:0] e_wacc;
  logic [SW-1:0] o_wdata;
  logic [7:0] rd_prio;
  logic [20:0] rd_per;
  logic [31:0] rd_acc;
  logic [SW-1:0] rd_ord;

  always_ff @(posedge clk) begin
    if (e_we) begin
      mem_prio[e_addr] <= e_wprio;
      mem_per[e_addr] <= e_wper;
      mem_acc[e_addr] <= e_wacc;
    end
    rd_prio <= mem_prio[e_addr];
    rd_per <= mem_per[e_addr];
    rd_acc <= mem_acc[e_addr];
  end
  always_ff @(posedge clk) begin
    if (o_we) mem_ord[o_waddr] <= o_wdata;
    rd_ord <= mem_ord[o_raddr];
  end

  logic [MAX_TASKS-1:0] valid, active;
  logic [LW-1:0] olen;
  logic [16:0] reload;
  logic [16:0] legacy;
  logic [27:0] tclock;
  logic susp;

  // request latch
  logic [2:0] op;
  logic [3:0] rslot;
  logic [20:0] rfreq;
  logic [7:0] rprio;
  logic [20:0] period;
  logic [SW-1:0] newslot;
  logic [LW-1:0] idx, wpos;
  logic [5:0] fires;
  logic [31:0] acc;
  logic [SW-1:0] cur;
  logic [16:0] minp;
  logic [20:0] curper;
  logic [7:0] curprio;
  logic curact;
  logic [1:0] status;
  logic [3:0] slot_res;
  logic found_pos;
  logic chain;
  logic div_start, div_done;
  logic [20:0] div_q;
  result_t out_r;

  ptts_divider #(.CLOCK_BASE(CLOCK_BASE)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(rfreq),
    .done(div_done), .quotient(div_q)
  );

  logic accept;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept = s_tvalid && s_tready;

  logic slot_ok;
  assign slot_ok = (32'(rslot) < MAX_TASKS) && valid[rslot[SW-1:0]];

  logic [SW-1:0] lowfree;
  logic anyfree;
  always_comb begin
    lowfree = '0;
    anyfree = 1'b0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        lowfree = SW'(i);
        anyfree = 1'b1;
      end
    end
  end

  // accumulator add with saturation
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  assign acc_sum = {1'b0, rd_acc} + 33'(reload);
  assign acc_sat = acc_sum[32] ? 32'hffffffff : acc_sum[31:0];

  logic can_fire;
  assign can_fire = curact && !susp && (32'(fires) < MAX_FIRES_PER_TICK) && (curper != '0)
    && (acc >= 32'(curper));

  logic [17:0] leg_sum;
  assign leg_sum = {1'b0, legacy} + {1'b0, reload};
  assign chain = leg_sum > 18'h0ffff;

  logic out_load;
  assign out_load = (!m_tvalid || m_tready) &&
    ((state == S_FIRE && can_fire) || state == S_EMIT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        if (s_tdata[2:0] == OP_TICK) state_next = S_TICK_RD;
        else if (s_tdata[2:0] == OP_ADD || s_tdata[2:0] == OP_CHANGE) state_next = S_DIV;
        else state_next = S_DECIDE;
      end
      S_DIV: if (div_done) state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_EMIT;
        if (op == OP_ADD && period != '0 && anyfree) state_next = S_SCAN_RD;
        else if (op == OP_CHANGE && slot_ok && period != '0) state_next = S_MIN_RD;
        else if (op == OP_REMOVE && slot_ok) state_next = S_UNL_RD;
      end
      S_SCAN_RD: state_next = (idx < olen) ? S_SCAN : S_INS_RD;
      S_SCAN: state_next = S_SCAN_RD;
      S_INS_RD: state_next = S_INS;
      S_INS: state_next = (idx == wpos) ? S_EMIT : S_INS;
      S_UNL_RD: state_next = (idx < olen) ? S_UNL : S_MIN_RD;
      S_UNL: state_next = S_UNL_RD;
      S_MIN_RD: state_next = (idx < olen) ? S_MIN : S_EMIT;
      S_MIN: state_next = S_MIN_RD;
      S_TICK_RD: state_next = (idx < olen) ? S_TICK : S_EMIT;
      S_TICK: state_next = S_FIRE;
      S_FIRE: if (!m_tvalid || m_tready) begin
        if (!can_fire) state_next = S_TICK_RD;
      end
      S_EMIT: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory addressing; order reads run one entry ahead of their use
  always_comb begin
    o_raddr = idx[SW-1:0];
    e_addr = rd_ord;
    e_we = 1'b0;
    e_wprio = rprio;
    e_wper = period;
    e_wacc = acc;
    o_we = 1'b0;
    o_waddr = idx[SW-1:0];
    o_wdata = rd_ord;
    div_start = (state == S_IDLE) && accept &&
      (s_tdata[2:0] == OP_ADD || s_tdata[2:0] == OP_CHANGE);
    unique case (state)
      S_IDLE: o_raddr = '0;
      // change rate keeps priority and accum: read them during the divide
      S_DIV: e_addr = rslot[SW-1:0];
      S_SCAN: begin
        e_addr = rd_ord;
        o_raddr = SW'(idx + 1'b1);
      end
      S_INS_RD: o_raddr = SW'(olen - 1'b1);
      S_INS: begin
        // shift order tail up one place, newest slot lands at wpos
        o_we = 1'b1;
        if (idx == wpos) o_wdata = newslot;
        else o_wdata = rd_ord;
        o_waddr = idx[SW-1:0];
        o_raddr = SW'(idx - 2'd2);
      end
      S_UNL_RD: o_raddr = (idx < olen) ? idx[SW-1:0] : '0;
      S_UNL: begin
        o_we = (rd_ord != rslot[SW-1:0]);
        o_waddr = wpos[SW-1:0];
        o_wdata = rd_ord;
        o_raddr = SW'(idx + 1'b1);
      end
      S_MIN: o_raddr = SW'(idx + 1'b1);
      S_DECIDE: if (op == OP_ADD) begin
        e_addr = lowfree;
        e_we = (period != '0) && anyfree;
        e_wacc = '0;
      end else if (op == OP_CHANGE) begin
        e_addr = rslot[SW-1:0];
        e_we = slot_ok && (period != '0);
        e_wprio = rd_prio;
        e_wacc = rd_acc;
      end
      S_FIRE: begin
        e_addr = cur;
        e_we = curact;
        e_wprio = curprio;
        e_wper = curper;
        e_wacc = can_fire ? acc - 32'(curper) : acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      active <= '0;
      olen <= '0;
      reload <= RELOAD_MAX;
      legacy <= '0;
      tclock <= '0;
      susp <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          op <= s_tdata[2:0];
          rslot <= s_tdata[6:3];
          rfreq <= s_tdata[27:7];
          rprio <= s_tdata[35:28];
          idx <= '0;
          wpos <= '0;
          fires <= '0;
          status <= ST_OK;
          slot_res <= '0;
          found_pos <= 1'b0;
          minp <= RELOAD_MAX;
          if (s_tdata[2:0] == OP_TICK) tclock <= tclock + 28'd1;
        end
        // a zero frequency has no period
        S_DIV: if (div_done) period <= (rfreq == '0) ? '0 : div_q;
        S_DECIDE: begin
          unique case (op)
            OP_ADD: begin
              if (period == '0) status <= ST_BADFREQ;
              else if (!anyfree) status <= ST_FULL;
              else begin
                newslot <= lowfree;
                slot_res <= 4'(lowfree);
                valid[lowfree] <= 1'b1;
                active[lowfree] <= 1'b0;
                if (32'(period) < 32'(reload)) reload <= period[16:0];
                wpos <= olen;
              end
            end
            OP_CHANGE: begin
              slot_res <= rslot;
              if (!slot_ok) status <= ST_NOTFOUND;
              else if (period == '0) status <= ST_BADFREQ;
            end
            OP_REMOVE: begin
              slot_res <= rslot;
              if (!slot_ok) status <= ST_NOTFOUND;
              else begin
                valid[rslot[SW-1:0]] <= 1'b0;
                active[rslot[SW-1:0]] <= 1'b0;
              end
            end
            OP_ACTIVATE: active <= active | valid;
            OP_CLEAR: begin
              valid <= '0;
              active <= '0;
              olen <= '0;
            end
            OP_SUSPEND: susp <= 1'b1;
            OP_RESUME: susp <= 1'b0;
            default: ;
          endcase
        end
        S_SCAN_RD: ;
        S_SCAN: begin
          // rd_prio is priority of order entry idx
          if (!found_pos && rd_prio < rprio) begin
            found_pos <= 1'b1;
            wpos <= idx;
          end
          idx <= idx + 1'b1;
        end
        S_INS_RD: begin
          if (olen >= NT) olen <= NT - 1'b1;
          idx <= (olen >= NT) ? NT - 1'b1 : olen;
          if (!found_pos) wpos <= (olen >= NT) ? NT - 1'b1 : olen;
        end
        S_INS: begin
          if (idx == wpos) olen <= olen + 1'b1;
          else idx <= idx - 1'b1;
        end
        S_UNL: begin
          if (rd_ord != rslot[SW-1:0]) wpos <= wpos + 1'b1;
          idx <= idx + 1'b1;
        end
        S_UNL_RD: if (idx >= olen) begin
          olen <= wpos;
          idx <= '0;
        end
        S_MIN: begin
          if (32'(rd_per) < 32'(minp)) minp <= rd_per[16:0];
          idx <= idx + 1'b1;
        end
        S_MIN_RD: if (idx >= olen) begin
          if (minp != reload) reload <= (minp == '0) ? RELOAD_MAX : minp;
        end
        S_TICK_RD: ;
        S_TICK: begin
          cur <= rd_ord;
          curper <= rd_per;
          curprio <= rd_prio;
          curact <= active[rd_ord];
          acc <= active[rd_ord] ? acc_sat : rd_acc;
          idx <= idx + 1'b1;
        end
        S_FIRE: if (!m_tvalid || m_tready) begin
          if (can_fire) begin
            acc <= acc - 32'(curper);
            fires <= fires + 6'd1;
            out_r <= '{KIND_FIRE, 4'(cur), ST_OK, reload, tclock, 1'b0, 1'b0};
          end
        end
        S_EMIT: if (!m_tvalid || m_tready) begin
          if (op == OP_TICK) begin
            legacy <= chain ? {1'b0, leg_sum[15:0]} : leg_sum[16:0];
            out_r <= '{KIND_TICK, 4'd0, ST_OK, reload, tclock, chain, 1'b1};
          end else begin
            out_r <= '{KIND_OP, slot_res, status, reload, tclock, 1'b0, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign m_tdata = {4'd0, out_r.chain, out_r.clock, out_r.reload, out_r.status, out_r.slot};
  assign m_tuser = out_r.kind;
  assign m_tlast = out_r.last;

  a_reload_range: assert property (@(posedge clk) disable iff (rst)
    reload != '0 && reload <= RELOAD_MAX) else $error("reload out of range");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready) else $error("ready while busy");
  a_olen: assert property (@(posedge clk) disable iff (rst)
    olen <= NT) else $error("order length overflow");
  a_fires: assert property (@(posedge clk) disable iff (rst)
    32'(fires) <= MAX_FIRES_PER_TICK) else $error("fire limit exceeded");
endmodule
`default_nettype wire

### rtl/ptts_divider.sv
`default_nettype none
// Restoring divider: CLOCK_BASE / frequency, one quotient bit per cycle.
module ptts_divider #(
  parameter int CLOCK_BASE = 1193182
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [20:0] divisor,
  output logic done,
  output logic [20:0] quotient
);
  localparam logic [20:0] DIVIDEND = 21'(CLOCK_BASE);
  logic [20:0] rem;
  logic [20:0] dvd;
  logic [4:0] count;
  logic busy;
  logic [21:0] trial;

  assign trial = {rem, dvd[20]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= '0;
        dvd <= DIVIDEND;
        quotient <= '0;
        count <= 5'd0;
      end else if (busy) begin
        if (!trial[21]) begin
          rem <= trial[20:0];
        end else begin
          rem <= {rem[19:0], dvd[20]};
        end
        dvd <= {dvd[19:0], 1'b0};
        quotient <= {quotient[19:0], ~trial[21]};
        count <= count + 5'd1;
        if (count == 5'd20) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
